>>> design/mu8_pkg.sv
package mu8_pkg;

  // Default depth of the queue between front and back
  localparam int QDEPTH_DEF = 4;

  // Result byte counts carried by one queue entry
  localparam logic [2:0] NB_MARKER = 3'd0;
  localparam logic [2:0] NB_ONE    = 3'd1;
  localparam logic [2:0] NB_PAIR   = 3'd6;

  // Sequence lengths set by a lead byte
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Code point window that maps to a surrogate pair
  localparam logic [20:0] CP_MIN   = 21'h010000;
  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [15:0] SURR_HI  = 16'hD800;
  localparam logic [15:0] SURR_LO  = 16'hDC00;

  // All results caused by one input byte
  typedef struct packed {
    logic [2:0]      nbytes;  // NB_MARKER: one empty end marker
    logic [5:0][7:0] bytes;   // bytes[0] goes out first
  } q_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Sequence length given by a lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] c);
    logic [2:0] len;
    len = LEN_NONE;
    if (c[7] == 1'b0)               len = LEN_1;
    else if (c[7:5] == 3'b110)      len = LEN_2;
    else if (c[7:4] == 4'b1110)     len = LEN_3;
    else if (c[7:3] == 5'b11110)    len = LEN_4;
    return len;
  endfunction

  // Three-byte sequence for a 16-bit unit, lead byte in the top byte
  function automatic logic [23:0] encode3(input logic [15:0] u);
    return {8'hE0 | {4'b0, u[15:12]}, 8'h80 | {2'b0, u[11:6]}, 8'h80 | {2'b0, u[5:0]}};
  endfunction

endpackage

>>> design/mu8_front.sv
module mu8_front import mu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output q_entry_t   q_wdata
);

  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [2:0] exp_len_r, exp_len_nxt;

  logic        accept;
  logic        cont;
  logic [2:0]  len;
  logic        wr_held;
  logic [1:0]  wr_idx;
  logic [20:0] cp;
  logic [19:0] v;
  logic [15:0] hi_unit, lo_unit;
  logic [23:0] hi_enc, lo_enc;

  assign accept = in_push && !q_stat.full;
  assign cont   = (in_byte[7:6] == 2'b10);
  assign len    = lead_length(in_byte);

  // Decode a four-byte sequence and split it into surrogates
  assign cp      = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0], in_byte[5:0]};
  assign v       = 20'(cp - CP_MIN);
  assign hi_unit = SURR_HI + {6'b0, v[19:10]};
  assign lo_unit = SURR_LO + {6'b0, v[9:0]};
  assign hi_enc  = encode3(hi_unit);
  assign lo_enc  = encode3(lo_unit);

  // Classify the byte and build its queue entry
  always_comb begin
    held_cnt_nxt = held_cnt_r;
    exp_len_nxt  = exp_len_r;
    wr_held      = 1'b0;
    wr_idx       = held_cnt_r;
    q_wdata      = '0;
    q_wdata.nbytes = NB_MARKER;
    if (exp_len_r != LEN_NONE && cont) begin
      if ({1'b0, held_cnt_r} + 3'd1 >= exp_len_r) begin
        if (exp_len_r < LEN_4) begin
          q_wdata.nbytes   = {1'b0, held_cnt_r} + 3'd1;
          q_wdata.bytes[0] = held_r[0];
          q_wdata.bytes[1] = (held_cnt_r == 2'd1) ? in_byte : held_r[1];
          q_wdata.bytes[2] = in_byte;
        end else if (cp >= CP_MIN && cp <= CP_MAX) begin
          q_wdata.nbytes   = NB_PAIR;
          q_wdata.bytes[0] = hi_enc[23:16];
          q_wdata.bytes[1] = hi_enc[15:8];
          q_wdata.bytes[2] = hi_enc[7:0];
          q_wdata.bytes[3] = lo_enc[23:16];
          q_wdata.bytes[4] = lo_enc[15:8];
          q_wdata.bytes[5] = lo_enc[7:0];
        end
        held_cnt_nxt = 2'd0;
        exp_len_nxt  = LEN_NONE;
      end else begin
        wr_held      = 1'b1;
        held_cnt_nxt = held_cnt_r + 2'd1;
      end
    end else begin
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = LEN_NONE;
      if (len == LEN_1) begin
        q_wdata.nbytes   = NB_ONE;
        q_wdata.bytes[0] = in_byte;
      end else if (len != LEN_NONE) begin
        wr_held      = 1'b1;
        wr_idx       = 2'd0;
        held_cnt_nxt = 2'd1;
        exp_len_nxt  = len;
      end
    end
    // Drop any partial sequence at end of text
    if (in_end_of_text) begin
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = LEN_NONE;
    end
  end

  assign q_push = accept;

  // Advance sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      exp_len_r  <= LEN_NONE;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
      exp_len_r  <= exp_len_nxt;
    end
  end

  // Hold bytes of the pending sequence
  always_ff @(posedge clk) begin
    if (accept && wr_held) begin
      case (wr_idx)
        2'd0:    held_r[0] <= in_byte;
        2'd1:    held_r[1] <= in_byte;
        2'd2:    held_r[2] <= in_byte;
        default: held_r[1] <= in_byte;
      endcase
    end
  end

endmodule

>>> design/mu8_queue.sv
module mu8_queue import mu8_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output q_stat_t  stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    if (pop)  rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue occupancy above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("pop from empty queue");

endmodule

>>> design/mu8_back.sv
module mu8_back import mu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   q_rdata,
  input  q_stat_t    q_stat,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_run_last
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       present_r, last_r;

  logic       load;
  logic       is_marker;
  logic       beat_last;
  logic [7:0] beat_byte;

  assign is_marker = (q_rdata.nbytes == NB_MARKER);
  assign beat_last = is_marker || (idx_r == q_rdata.nbytes - 3'd1);
  assign load      = !q_stat.empty && (!valid_r || out_pop);

  // Pick the current beat from the head entry
  always_comb begin
    case (idx_r)
      3'd0:    beat_byte = q_rdata.bytes[0];
      3'd1:    beat_byte = q_rdata.bytes[1];
      3'd2:    beat_byte = q_rdata.bytes[2];
      3'd3:    beat_byte = q_rdata.bytes[3];
      3'd4:    beat_byte = q_rdata.bytes[4];
      3'd5:    beat_byte = q_rdata.bytes[5];
      default: beat_byte = 8'h00;
    endcase
    if (is_marker) beat_byte = 8'h00;
  end

  // Step through the entry; retire it on its last beat
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    q_pop     = 1'b0;
    if (out_pop && valid_r) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (beat_last) begin
        idx_nxt = 3'd0;
        q_pop   = 1'b1;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= beat_byte;
      present_r <= !is_marker;
      last_r    <= beat_last;
    end
  end

  assign out_empty        = !valid_r;
  assign out_byte         = byte_r;
  assign out_byte_present = present_r;
  assign out_run_last     = last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < NB_PAIR) else $error("beat index out of range");
  a_mid_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 3'd0) |-> !q_stat.empty) else $error("entry in progress but queue empty");
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !present_r) |-> last_r) else $error("end marker without last flag");

endmodule

>>> design/utf8_to_modified_utf8.sv
// Results of an accepted byte pass through the queue, then the output register.
// Throughput: one input byte per cycle while each byte yields one result and out_pop
// is high; a byte with several results holds the output stage until each is popped, and
// in_full stalls the front only once the QDEPTH-entry queue between front and back fills.
// Reset: synchronous, active low; clears sequence state, queue and output valid.
module utf8_to_modified_utf8 import mu8_pkg::*; #(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_run_last
);

  q_stat_t  q_stat;
  q_entry_t q_wdata, q_rdata;
  logic     q_push, q_pop;

  assign in_full = q_stat.full;

  mu8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  mu8_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mu8_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rdata          (q_rdata),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_run_last     (out_run_last)
  );

endmodule

>>> tb/utf8_to_modified_utf8_test.sv
module utf8_to_modified_utf8_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Sequence lengths set by a lead byte
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_1    = 3'd1;
  localparam logic [2:0] SEQ_2    = 3'd2;
  localparam logic [2:0] SEQ_3    = 3'd3;
  localparam logic [2:0] SEQ_4    = 3'd4;

  // Code point window that becomes a surrogate pair
  localparam logic [20:0] SUPP_FIRST = 21'h010000;
  localparam logic [20:0] SUPP_LAST  = 21'h10FFFF;
  localparam logic [15:0] HIGH_BASE  = 16'hD800;
  localparam logic [15:0] LOW_BASE   = 16'hDC00;

  localparam int RANDOM_BYTES = 480;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_LEN     = 300;
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       last;
  } out_beat_t;

  // Re-encoder prediction plus the queue of beats still due at the output
  class mutf8_board;
    out_beat_t  due_out[$];
    out_beat_t  run[$];
    logic [7:0] held[3];
    logic [1:0] held_n;
    logic [2:0] seq_len;
    int         mismatches;

    function new();
      held_n     = '0;
      seq_len    = SEQ_NONE;
      mismatches = 0;
    endfunction

    function void add_beat(logic [7:0] b);
      out_beat_t e;
      e.data    = b;
      e.present = 1'b1;
      e.last    = 1'b0;
      run = {run, e};
    endfunction

    // Emit one 16-bit unit as a three-byte sequence
    function void add_unit(logic [15:0] u);
      add_beat(8'hE0 | {4'b0, u[15:12]});
      add_beat(8'h80 | {2'b0, u[11:6]});
      add_beat(8'h80 | {2'b0, u[5:0]});
    endfunction

    function void note_in_byte(logic [7:0] c, logic eot);
      logic [20:0] cp;
      logic [20:0] v;
      logic [2:0]  len;
      out_beat_t   e;
      run.delete();
      if (seq_len != SEQ_NONE && c[7:6] == 2'b10) begin
        if (int'(held_n) + 1 >= int'(seq_len)) begin
          if (seq_len != SEQ_4) begin
            for (int i = 0; i < int'(held_n); i++) add_beat(held[i]);
            add_beat(c);
          end else begin
            cp = {held[0][2:0], held[1][5:0], held[2][5:0], c[5:0]};
            if (cp >= SUPP_FIRST && cp <= SUPP_LAST) begin
              v = cp - SUPP_FIRST;
              add_unit(HIGH_BASE + {6'b0, v[19:10]});
              add_unit(LOW_BASE + {6'b0, v[9:0]});
            end
          end
          held_n  = '0;
          seq_len = SEQ_NONE;
        end else begin
          held[held_n] = c;
          held_n++;
        end
      end else begin
        // Any non-continuation byte drops a pending sequence and starts afresh
        held_n  = '0;
        seq_len = SEQ_NONE;
        if (c[7] == 1'b0)            len = SEQ_1;
        else if (c[7:5] == 3'b110)   len = SEQ_2;
        else if (c[7:4] == 4'b1110)  len = SEQ_3;
        else if (c[7:3] == 5'b11110) len = SEQ_4;
        else                         len = SEQ_NONE;
        if (len == SEQ_1) begin
          add_beat(c);
        end else if (len != SEQ_NONE) begin
          held[0] = c;
          held_n  = 2'd1;
          seq_len = len;
        end
      end
      // Drop whatever is still incomplete at the end of the text
      if (eot) begin
        held_n  = '0;
        seq_len = SEQ_NONE;
      end
      if (run.size() == 0) begin
        e.data    = 8'h00;
        e.present = 1'b0;
        e.last    = 1'b1;
        run = {run, e};
      end else begin
        run[run.size() - 1].last = 1'b1;
      end
      due_out = {due_out, run};
    endfunction

    function void flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
    endfunction

    function void check_out_beat(logic [7:0] b, logic p, logic l);
      out_beat_t e;
      if (due_out.size() == 0) begin
        flag_mismatch("unexpected beat", b, 8'h00);
      end else begin
        e = due_out.pop_front();
        if (b !== e.data)    flag_mismatch("out_byte", b, e.data);
        if (p !== e.present) flag_mismatch("out_byte_present", {7'b0, p}, {7'b0, e.present});
        if (l !== e.last)    flag_mismatch("out_run_last", {7'b0, l}, {7'b0, e.last});
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_byte_present;
  logic       out_run_last;

  mutf8_board board = new();
  int         burst_left = 0;
  int         bytes_sent = 0;

  utf8_to_modified_utf8 u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_run_last     (out_run_last)
  );

  always #1 clk = ~clk;

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) board.note_in_byte(in_byte, in_end_of_text);
      if (out_pop && !out_empty) board.check_out_beat(out_byte, out_byte_present, out_run_last);
    end
  end

  // Append one byte to a sequence under construction
  function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q = {q, b};
  endfunction

  // Offer one byte, with random gaps between bursts, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_push = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_push        = 1'b1;
    in_byte        = b;
    in_end_of_text = eot;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  // Send a byte sequence, with the end flag set now and then
  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], $urandom_range(0, 15) == 0);
  endtask

  // Mostly well-formed characters with random content, some broken ones and noise
  task automatic send_random_char();
    logic [7:0]  seq[$];
    logic [20:0] cp;
    int          kind;
    int          len;
    int          keep;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      append_byte(seq, 8'($urandom_range(1, 127)));
    end else if (kind < 35) begin
      append_byte(seq, {3'b110, 5'($urandom)});
      append_byte(seq, {2'b10, 6'($urandom)});
    end else if (kind < 50) begin
      append_byte(seq, {4'b1110, 4'($urandom)});
      repeat (2) append_byte(seq, {2'b10, 6'($urandom)});
    end else if (kind < 72) begin
      cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
      append_byte(seq, {5'b11110, cp[20:18]});
      append_byte(seq, {2'b10, cp[17:12]});
      append_byte(seq, {2'b10, cp[11:6]});
      append_byte(seq, {2'b10, cp[5:0]});
    end else if (kind < 80) begin
      append_byte(seq, {5'b11110, 3'($urandom)});
      repeat (3) append_byte(seq, {2'b10, 6'($urandom)});
    end else if (kind < 90) begin
      // Cut short; the next lead or ASCII byte breaks it
      len  = $urandom_range(2, 4);
      keep = $urandom_range(0, len - 2);
      case (len)
        2:       append_byte(seq, {3'b110, 5'($urandom)});
        3:       append_byte(seq, {4'b1110, 4'($urandom)});
        default: append_byte(seq, {5'b11110, 3'($urandom)});
      endcase
      repeat (keep) append_byte(seq, {2'b10, 6'($urandom)});
    end else begin
      append_byte(seq, 8'($urandom_range(1, 255)));
    end
    send_seq(seq);
  endtask

  // Receiver: own pop pattern, with one long hold-off to fill the block
  initial begin
    int         cyc;
    int         mode;
    logic [7:0] mask;
    out_pop = 1'b0;
    cyc     = 0;
    mode    = 0;
    mask    = '0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (cyc % 48 == 0) begin
        mode = $urandom_range(0, 3);
        mask = 8'($urandom);
      end
      if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
        out_pop = 1'b0;
      end else begin
        case (mode)
          0:       out_pop = 1'b1;
          1:       out_pop = 1'($urandom_range(0, 1));
          2:       out_pop = mask[cyc % 8];
          default: out_pop = ($urandom_range(0, 3) == 0);
        endcase
      end
      cyc++;
    end
  end

  // Watchdog: end the run after too many cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("utf8_to_modified_utf8 verification failed");
    $finish;
  end

  initial begin
    logic [8:0] directed[$];
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    // {end flag, byte}
    directed = '{
      9'h17F,                          // ASCII max, end of text
      9'h001,                          // ASCII min
      9'h0C0, 9'h080,                  // overlong two-byte passes through
      9'h0E2, 9'h082, 9'h0AC,          // three-byte
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // highest code point
      9'h0F4, 9'h090, 9'h080, 9'h080,  // above the code point range
      9'h0F0, 9'h08F, 9'h080, 9'h080,  // below the supplementary range
      9'h0FF,                          // invalid lead
      9'h080,                          // stray continuation
      9'h0E2, 9'h041,                  // broken by ASCII
      9'h0E2, 9'h182                   // truncated by end of text
    };
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    while (bytes_sent < RANDOM_BYTES + directed.size()) send_random_char();
    @(negedge clk);
    in_push = 1'b0;

    // Drain, then give the pipeline time to show any stray beat
    while (board.due_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (board.mismatches == 0 && board.due_out.size() == 0) begin
      $display("utf8_to_modified_utf8 verification clean");
    end else begin
      $display("utf8_to_modified_utf8 verification failed");
    end
    $finish;
  end

endmodule
